// ----- src/ppu_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package ppu_pkg;

  localparam int POOL_DEPTH = 32;
  localparam int ADDR_W     = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int CNT_W      = 7;
  localparam int IN_DATA_W  = 224;
  localparam int OUT_DATA_W = 128;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(POOL_DEPTH);

  localparam logic [1:0] KIND_PARTICLE = 2'd0;
  localparam logic [1:0] KIND_EMPTY    = 2'd1;
  localparam logic [1:0] KIND_ACK      = 2'd2;

  localparam logic MODE_TICK  = 1'b0;
  localparam logic MODE_SPAWN = 1'b1;

  typedef struct packed {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] vel_x;
    logic [31:0] vel_y;
    logic [31:0] birth;
    logic [15:0] size;
    logic [15:0] life;
    logic [31:0] rgba;
  } row_t;

  typedef struct packed {
    logic load;
    logic clk_upd;
    logic spawn_wr;
    logic ack_ld;
    logic scan_rd;
    logic scan_ev;
    logic scan_wr;
    logic scan_fin;
    logic emit_rd;
    logic emit_ld;
    logic empty_ld;
  } cmd_t;

  typedef struct packed {
    logic mode;
    logic add_zero;
    logic scan_end;
    logic keep_zero;
    logic emit_last;
    logic out_free;
  } stat_t;

endpackage
`default_nettype wire

// ----- src/particle_pool_update.sv -----
`timescale 1ns / 1ps
`default_nettype none
// channel | dir | handshake             | contents
// in      | in  | in_tvalid/in_tready   | tuser mode, tdata request fields
// out     | out | out_tvalid/out_tready | tuser kind, tlast, tdata result
// cfg     | in  | cfg_valid/cfg_ready   | cfg_data time_rate
//
// a spawn loads the request, stores its n particles and then sends its acknowledge
// a tick updates the clock, then reads, evaluates and writes back each stored
// particle in a single-port store scan, then reads each survivor back out
// reset clears clock and occupancy and sets the rate to one; the store
// itself is not cleared
// a stalled output holds the sequencer, the output register lets the
// next request in once the last result is loaded
module particle_pool_update (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  // mode
  input  wire logic          in_tuser,
  // delta, spawn_count, start_x, start_y, particle_size, rgba,
  // speed_x, speed_y, lifetime, zero pad
  input  wire logic [223:0]  in_tdata,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  // kind
  output logic [1:0]         out_tuser,
  output logic               out_tlast,
  // out_x, out_y, out_size, out_rgba, live_count, dropped_count, zero pad
  output logic [127:0]       out_tdata,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [10:0]   cfg_data
);

  ppu_pkg::cmd_t  cmd;
  ppu_pkg::stat_t stat;

  // the rate register is always writable
  assign cfg_ready = 1'b1;

  ppu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ppu_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_mode   (in_tuser),
    .in_data   (in_tdata),
    .cfg_we    (cfg_valid),
    .cfg_value (cfg_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_kind  (out_tuser),
    .out_last  (out_tlast),
    .out_data  (out_tdata)
  );

  // acknowledge and empty results stand alone
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ppu_pkg::KIND_PARTICLE |-> out_tlast)
    else $error("single result without last");

  // an empty tick leaves nothing in the pool
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ppu_pkg::KIND_EMPTY |-> out_tdata[118:112] == 7'd0)
    else $error("empty tick with live particles");

  // pool never exceeds its depth
  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[118:112] <= ppu_pkg::DEPTH_CNT)
    else $error("live count beyond depth");

endmodule
`default_nettype wire

// ----- src/ppu_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module ppu_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  ppu_pkg::stat_t     stat,
  output ppu_pkg::cmd_t      cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_CLK, S_SPAWN, S_ACK, S_SCAN_RD, S_SCAN_EV, S_SCAN_WR,
    S_FIN, S_EMIT_RD, S_EMIT_LD, S_EMPTY
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = (stat.mode == ppu_pkg::MODE_SPAWN) ? S_SPAWN : S_CLK;
        end
      end
      S_CLK: begin
        cmd.clk_upd = 1'b1;
        state_nxt   = S_SCAN_RD;
      end
      S_SPAWN: begin
        if (stat.add_zero) state_nxt = S_ACK;
        else cmd.spawn_wr = 1'b1;
      end
      S_ACK: begin
        if (stat.out_free) begin
          cmd.ack_ld = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_SCAN_RD: begin
        if (stat.scan_end) state_nxt = S_FIN;
        else begin
          cmd.scan_rd = 1'b1;
          state_nxt   = S_SCAN_EV;
        end
      end
      S_SCAN_EV: begin
        cmd.scan_ev = 1'b1;
        state_nxt   = S_SCAN_WR;
      end
      S_SCAN_WR: begin
        cmd.scan_wr = 1'b1;
        state_nxt   = S_SCAN_RD;
      end
      S_FIN: begin
        cmd.scan_fin = 1'b1;
        state_nxt    = stat.keep_zero ? S_EMPTY : S_EMIT_RD;
      end
      S_EMIT_RD: begin
        cmd.emit_rd = 1'b1;
        state_nxt   = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        if (stat.out_free) begin
          cmd.emit_ld = 1'b1;
          state_nxt   = stat.emit_last ? S_IDLE : S_EMIT_RD;
        end
      end
      S_EMPTY: begin
        if (stat.out_free) begin
          cmd.empty_ld = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

endmodule
`default_nettype wire

// ----- src/ppu_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
module ppu_dp (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  ppu_pkg::cmd_t                         cmd,
  output ppu_pkg::stat_t                        stat,
  input  wire logic                             in_mode,
  input  wire logic [ppu_pkg::IN_DATA_W-1:0]    in_data,
  input  wire logic                             cfg_we,
  input  wire logic [10:0]                      cfg_value,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [1:0]                            out_kind,
  output logic                                  out_last,
  output logic [ppu_pkg::OUT_DATA_W-1:0]        out_data
);

  localparam int AW = ppu_pkg::ADDR_W;
  localparam int CW = ppu_pkg::CNT_W;

  ppu_pkg::row_t mem [ppu_pkg::POOL_DEPTH];
  ppu_pkg::row_t rd_r, new_row;

  logic [10:0]   rate_r;
  logic [31:0]   pclk_r;
  logic [CW-1:0] occ_r, idx_r, keep_r, emit_r, add_r, drop_r;
  logic [23:0]   dt_r;
  ppu_pkg::row_t in_row_r;

  logic [56:0] px_r, py_r;
  logic        alive_r;

  logic          out_valid_r, out_last_r;
  logic [1:0]    out_kind_r;
  logic [31:0]   out_x_r, out_y_r, out_rgba_r;
  logic [15:0]   out_size_r;
  logic [CW-1:0] out_live_r, out_drop_r;

  logic [CW-1:0] cnt_in, space;
  logic [34:0]   adv;
  logic [35:0]   csum;
  logic [48:0]   death;
  logic [AW-1:0] rd_addr;

  assign cnt_in  = in_data[30:24];
  assign space   = ppu_pkg::DEPTH_CNT - occ_r;
  assign adv     = 35'(rate_r) * 35'(dt_r);
  assign csum    = {4'd0, ((occ_r == '0) ? 32'd0 : pclk_r)} + {1'b0, adv};
  assign death   = {17'd0, rd_r.birth} + {17'd0, rd_r.life, 16'd0};
  assign rd_addr = cmd.emit_rd ? emit_r[AW-1:0] : idx_r[AW-1:0];

  always_comb begin
    new_row       = rd_r;
    new_row.pos_x = rd_r.pos_x + px_r[47:16];
    new_row.pos_y = rd_r.pos_y + py_r[47:16];
  end

  assign stat.mode      = in_mode;
  assign stat.add_zero  = (add_r == '0);
  assign stat.scan_end  = (idx_r == occ_r);
  assign stat.keep_zero = (keep_r == '0);
  assign stat.emit_last = (emit_r + CW'(1) == occ_r);
  assign stat.out_free  = !out_valid_r || out_ready;

  // store
  always_ff @(posedge clk) begin
    if (cmd.spawn_wr) mem[occ_r[AW-1:0]] <= in_row_r;
    else if (cmd.scan_wr && alive_r) mem[keep_r[AW-1:0]] <= new_row;
    if (cmd.scan_rd || cmd.emit_rd) rd_r <= mem[rd_addr];
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dt_r           <= in_data[23:0];
      in_row_r.pos_x <= in_data[62:31];
      in_row_r.pos_y <= in_data[94:63];
      in_row_r.size  <= in_data[110:95];
      in_row_r.rgba  <= in_data[142:111];
      in_row_r.vel_x <= in_data[174:143];
      in_row_r.vel_y <= in_data[206:175];
      in_row_r.life  <= in_data[222:207];
      in_row_r.birth <= pclk_r;
      add_r          <= (cnt_in < space) ? cnt_in : space;
      drop_r         <= (cnt_in < space) ? '0 : cnt_in - space;
    end else if (cmd.spawn_wr) begin
      add_r <= add_r - CW'(1);
    end
    if (cmd.scan_ev) begin
      px_r    <= $signed(rd_r.vel_x) * $signed({1'b0, dt_r});
      py_r    <= $signed(rd_r.vel_y) * $signed({1'b0, dt_r});
      alive_r <= ({17'd0, pclk_r} < death);
    end
    if (cmd.ack_ld || cmd.empty_ld) begin
      out_kind_r <= cmd.ack_ld ? ppu_pkg::KIND_ACK : ppu_pkg::KIND_EMPTY;
      out_x_r    <= '0;
      out_y_r    <= '0;
      out_size_r <= '0;
      out_rgba_r <= '0;
      out_live_r <= occ_r;
      out_drop_r <= cmd.ack_ld ? drop_r : '0;
      out_last_r <= 1'b1;
    end else if (cmd.emit_ld) begin
      out_kind_r <= ppu_pkg::KIND_PARTICLE;
      out_x_r    <= rd_r.pos_x;
      out_y_r    <= rd_r.pos_y;
      out_size_r <= rd_r.size;
      out_rgba_r <= rd_r.rgba;
      out_live_r <= occ_r;
      out_drop_r <= '0;
      out_last_r <= stat.emit_last;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r      <= 11'd1;
      pclk_r      <= '0;
      occ_r       <= '0;
      idx_r       <= '0;
      keep_r      <= '0;
      emit_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) rate_r <= cfg_value;
      if (cmd.clk_upd) begin
        pclk_r <= (csum[35:32] != 4'd0) ? 32'hFFFF_FFFF : csum[31:0];
        idx_r  <= '0;
        keep_r <= '0;
      end
      if (cmd.spawn_wr) occ_r <= occ_r + CW'(1);
      if (cmd.scan_wr) begin
        idx_r <= idx_r + CW'(1);
        if (alive_r) keep_r <= keep_r + CW'(1);
      end
      if (cmd.scan_fin) begin
        occ_r  <= keep_r;
        emit_r <= '0;
      end
      if (cmd.emit_ld) emit_r <= emit_r + CW'(1);
      if (cmd.ack_ld || cmd.empty_ld || cmd.emit_ld) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_last  = out_last_r;
  assign out_data  = {2'b00, out_drop_r, out_live_r, out_rgba_r, out_size_r,
                      out_y_r, out_x_r};

endmodule
`default_nettype wire
